>>> hw/rtl/tds_pkg.sv
package tds_pkg;

	localparam int DATA_W          = 32;
	localparam int DIV_W           = 16;
	localparam int CNT_W           = $clog2(DATA_W);
	localparam int MS_PER_SECOND   = 1000;
	localparam int MAX_DIVIDER_DEF = 65535;

	typedef logic [DATA_W-1:0] word_t;
	typedef logic [DIV_W-1:0]  div_t;

	localparam logic ST_OK     = 1'b0;
	localparam logic ST_NO_FIT = 1'b1;

endpackage

>>> hw/rtl/timer_divider_search.sv
// Sequence from acceptance to the done strobe: MUL1, DIV1, MUL2, then SRCH, which tries divisors
// in turn, 1 to MAX_DIVIDER-1, until one fits or the last one has been tried.
// Throughput: one transaction at a time; busy drops with done, so a new start is taken
// in the done cycle.
// All arithmetic runs through one bit-serial shift-add/restoring-divide datapath, one bit a cycle.
// Results are shown for one cycle on done; the receiver cannot stall.
// Reset (arst_n low, asynchronous) clears clock_rate to 0 and returns the sequencer to idle.
module timer_divider_search #(
	parameter int MAX_DIVIDER = tds_pkg::MAX_DIVIDER_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [tds_pkg::DATA_W-1:0]  scale_factor,
	input  logic [tds_pkg::DATA_W-1:0]  interval_millis,
	output logic                        done,
	output logic                        status,
	output logic [tds_pkg::DIV_W-1:0]   divider,
	output logic [tds_pkg::DATA_W-1:0]  reload,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [tds_pkg::DATA_W-1:0]  cfg_data
);

	localparam int DW = tds_pkg::DATA_W;
	localparam int VW = tds_pkg::DIV_W;
	localparam int CW = tds_pkg::CNT_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL1 = 3'd1;
	localparam logic [2:0] S_DIV1 = 3'd2;
	localparam logic [2:0] S_MUL2 = 3'd3;
	localparam logic [2:0] S_SRCH = 3'd4;

	localparam logic [DW-1:0] MAX_W  = DW'(MAX_DIVIDER);
	localparam logic [VW-1:0] LAST_D = VW'(MAX_DIVIDER - 1);

	logic [2:0]            state_q;
	logic [CW-1:0]         cnt_q;
	tds_pkg::word_t        clock_rate_q;
	tds_pkg::word_t        a_q;
	tds_pkg::word_t        b_q;
	tds_pkg::word_t        acc_q;
	tds_pkg::word_t        millis_q;
	tds_pkg::word_t        total_q;
	logic [VW-1:0]         rem_q;
	tds_pkg::div_t         dvs_q;
	tds_pkg::div_t         d_q;
	logic                  done_q;
	logic                  status_q;
	tds_pkg::div_t         divider_q;
	tds_pkg::word_t        reload_q;

	tds_pkg::word_t        acc_nx;
	logic [VW:0]           rem_sh;
	logic [VW+1:0]         diff;
	logic                  qbit;
	logic [VW-1:0]         rem_nx;
	tds_pkg::word_t        quo_nx;
	logic                  last;
	logic                  fit;
	logic                  fin;

	assign acc_nx = acc_q + (b_q[0] ? a_q : '0);
	assign rem_sh = {rem_q, b_q[DW-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
	assign qbit   = ~diff[VW+1];
	assign rem_nx = qbit ? diff[VW-1:0] : rem_sh[VW-1:0];
	assign quo_nx = {b_q[DW-2:0], qbit};
	assign last   = (cnt_q == CW'(DW - 1));
	assign fit    = (quo_nx < MAX_W) && (rem_nx == '0);
	assign fin    = last && (fit || d_q == LAST_D);

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign status    = status_q;
	assign divider   = divider_q;
	assign reload    = reload_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_rate_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			clock_rate_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_SRCH) && fin;
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (start) begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1: begin
					cnt_q <= cnt_q + 1'b1;
					if (last) state_q <= S_DIV1;
				end
				S_DIV1: begin
					cnt_q <= cnt_q + 1'b1;
					if (last) state_q <= S_MUL2;
				end
				S_MUL2: begin
					cnt_q <= cnt_q + 1'b1;
					if (last) state_q <= S_SRCH;
				end
				S_SRCH: begin
					cnt_q <= cnt_q + 1'b1;
					if (fin) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					a_q      <= clock_rate_q;
					b_q      <= scale_factor;
					acc_q    <= '0;
					millis_q <= interval_millis;
				end
			end
			S_MUL1: begin
				acc_q <= acc_nx;
				a_q   <= {a_q[DW-2:0], 1'b0};
				if (last) begin
					b_q   <= acc_nx;
					rem_q <= '0;
					dvs_q <= VW'(tds_pkg::MS_PER_SECOND);
				end else begin
					b_q   <= {1'b0, b_q[DW-1:1]};
				end
			end
			S_DIV1: begin
				rem_q <= rem_nx;
				if (last) begin
					a_q   <= quo_nx;
					b_q   <= millis_q;
					acc_q <= '0;
				end else begin
					b_q   <= quo_nx;
				end
			end
			S_MUL2: begin
				acc_q <= acc_nx;
				a_q   <= {a_q[DW-2:0], 1'b0};
				if (last) begin
					total_q <= acc_nx;
					b_q     <= acc_nx;
					rem_q   <= '0;
					dvs_q   <= VW'(1);
					d_q     <= VW'(1);
				end else begin
					b_q     <= {1'b0, b_q[DW-1:1]};
				end
			end
			S_SRCH: begin
				if (!last) begin
					rem_q <= rem_nx;
					b_q   <= quo_nx;
				end else if (fit) begin
					if (quo_nx == DW'(1)) begin
						status_q  <= tds_pkg::ST_NO_FIT;
						divider_q <= '0;
						reload_q  <= '0;
					end else begin
						status_q  <= tds_pkg::ST_OK;
						divider_q <= d_q;
						reload_q  <= quo_nx - DW'(1);
					end
				end else if (d_q == LAST_D) begin
					status_q  <= tds_pkg::ST_NO_FIT;
					divider_q <= '0;
					reload_q  <= '0;
				end else begin
					d_q   <= d_q + 1'b1;
					dvs_q <= d_q + 1'b1;
					b_q   <= total_q;
					rem_q <= '0;
				end
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

endmodule

>>> hw/rtl/tds_chk.sv
module tds_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic                        status,
	input logic [tds_pkg::DIV_W-1:0]   divider,
	input logic [tds_pkg::DATA_W-1:0]  reload
);

	// result only after the transaction has finished
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	a_nofit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == tds_pkg::ST_NO_FIT |-> divider == '0 && reload == '0)
		else $error("no_fit result with nonzero fields");

	a_ok_div: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == tds_pkg::ST_OK |-> divider != '0 && reload != '0)
		else $error("ok result with zero divider or reload");

endmodule

bind timer_divider_search tds_chk u_tds_chk (.*);
